FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_CLK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_RST(lbl, prop, msg)

`endif

`endif

FILE: rtl/vclp_pkg.sv
package vclp_pkg;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_PARSE  = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    localparam logic [1:0] RUN_NONE  = 2'd0;
    localparam logic [1:0] RUN_ONE   = 2'd1;
    localparam logic [1:0] RUN_TAKEN = 2'd2;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_V     = 8'h76;

    localparam logic [7:0] OPENER_TEXT [4] = '{8'h76, 8'h63, 8'h70, 8'h28};
    localparam logic [1:0] OPENER_LAST = 2'd3;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
        logic       is_open;
        logic       is_close;
        logic       is_v;
    } char_class_t;

    typedef struct packed {
        logic       code_valid;
        logic [7:0] vcp_code;
        logic       list_end;
        logic       list_found;
    } vclp_result_t;

endpackage

FILE: rtl/vclp_in_if.sv
interface vclp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/vclp_out_if.sv
interface vclp_out_if;
    logic       valid;
    logic       ready;
    logic       code_valid;
    logic [7:0] vcp_code;
    logic       list_end;
    logic       list_found;

    modport source (
        output valid, output code_valid, output vcp_code, output list_end,
        output list_found, input ready
    );
    modport sink (
        input valid, input code_valid, input vcp_code, input list_end,
        input list_found, output ready
    );
endinterface

FILE: rtl/vclp_char_class.sv
module vclp_char_class (
    input  logic [7:0]           char_code,
    output vclp_pkg::char_class_t cls
);
    import vclp_pkg::*;

    always_comb
    begin
        cls          = '0;
        cls.is_open  = (char_code == CH_OPEN);
        cls.is_close = (char_code == CH_CLOSE);
        cls.is_v     = (char_code == CH_V);
        if (char_code inside {[8'h30:8'h39]})
        begin
            cls.is_hex = 1'b1;
            cls.nibble = char_code[3:0];
        end
        else if (char_code inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            cls.is_hex = 1'b1;
            cls.nibble = 4'(char_code[3:0] + 4'd9);
        end
    end
endmodule

FILE: rtl/vclp_parse_core.sv
`include "assert_macros.svh"

module vclp_parse_core #(
    parameter int NEST_LIMIT = 255
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             char_code,
    input  logic                   last_char,
    input  vclp_pkg::char_class_t  cls,
    output vclp_pkg::vclp_result_t result
);
    import vclp_pkg::*;

    localparam int DEPTH_W = $clog2(NEST_LIMIT + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(NEST_LIMIT);

    phase_t             phase_reg, phase_next;
    logic [1:0]         matched_reg, matched_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [1:0]         run_reg, run_next;
    logic [3:0]         nibble_reg, nibble_next;
    logic [DEPTH_W-1:0] depth_dec;

    assign depth_dec = (depth_reg != '0) ? depth_reg - DEPTH_W'(1) : depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEARCH;
            matched_reg <= '0;
            depth_reg   <= '0;
            run_reg     <= RUN_NONE;
            nibble_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            matched_reg <= matched_next;
            depth_reg   <= depth_next;
            run_reg     <= run_next;
            nibble_reg  <= nibble_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        matched_next = matched_reg;
        depth_next   = depth_reg;
        run_next     = run_reg;
        nibble_next  = nibble_reg;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (char_code == OPENER_TEXT[matched_reg])
                begin
                    if (matched_reg == OPENER_LAST)
                    begin
                        phase_next   = PH_PARSE;
                        matched_next = '0;
                        depth_next   = DEPTH_W'(1);
                        run_next     = RUN_NONE;
                    end
                    else
                    begin
                        matched_next = matched_reg + 2'd1;
                    end
                end
                else
                begin
                    matched_next = {1'b0, cls.is_v};
                end
            end
            PH_PARSE:
            begin
                if (cls.is_hex)
                begin
                    if (run_reg == RUN_NONE)
                    begin
                        nibble_next = cls.nibble;
                        run_next    = RUN_ONE;
                    end
                    else if (run_reg == RUN_ONE)
                    begin
                        run_next = RUN_TAKEN;
                    end
                end
                else
                begin
                    run_next = RUN_NONE;
                    if (cls.is_open)
                    begin
                        if (depth_reg < DEPTH_MAX)
                            depth_next = depth_reg + DEPTH_W'(1);
                    end
                    else if (cls.is_close)
                    begin
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                            phase_next = PH_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // drop all state at the end of the string
        if (last_char)
        begin
            phase_next   = PH_SEARCH;
            matched_next = '0;
            depth_next   = '0;
            run_next     = RUN_NONE;
            nibble_next  = '0;
        end
    end

    // outputs
    always_comb
    begin
        result            = '0;
        result.list_end   = last_char;
        result.list_found = (phase_reg != PH_SEARCH) ||
                            (char_code == OPENER_TEXT[matched_reg] &&
                             matched_reg == OPENER_LAST);
        if (phase_reg == PH_PARSE && cls.is_hex && run_reg == RUN_ONE)
        begin
            result.code_valid = 1'b1;
            result.vcp_code   = {nibble_reg, cls.nibble};
        end
    end

    `ASSERT_CLK(a_code_only_in_parse, result.code_valid |-> phase_reg == PH_PARSE,
        "code emitted outside the list")
    `ASSERT_CLK(a_parse_depth_nonzero, phase_reg == PH_PARSE |-> depth_reg != '0,
        "parsing with zero depth")
    `ASSERT_CLK(a_last_clears, step && last_char |=>
        phase_reg == PH_SEARCH && matched_reg == '0 && depth_reg == '0,
        "state not cleared after last character")
    `ASSERT_CLK(a_hold_without_step, !step |=> $stable(phase_reg) && $stable(depth_reg),
        "state moved without an item")
endmodule

FILE: rtl/vcp_code_list_parser.sv
// Channel   Dir  Payload                                         Handshake
// char_in   in   char_code[7:0], last_char                       valid/ready
// code_out  out  code_valid, vcp_code[7:0], list_end, list_found valid/ready
//
// One result per character; an accepted character waits in the input register until the result register can take it.
// Sustains one character per cycle while code_out is ready: input register, parser logic, result register.
// The parser state advances only when an item moves into the result register.
// A stalled result holds; the input register still takes one more item.
// rst_n clears the parser to the search for the list opener.
`include "assert_macros.svh"

module vcp_code_list_parser #(
    parameter int NEST_LIMIT = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    vclp_in_if.sink    char_in,
    vclp_out_if.source code_out
);
    import vclp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    logic         last_reg;
    logic         out_valid_reg;
    vclp_result_t result_reg;
    logic         advance;
    char_class_t  cls;
    vclp_result_t result;

    assign advance       = in_valid_reg && (!out_valid_reg || code_out.ready);
    assign char_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_in.ready)
                in_valid_reg <= char_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (code_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            char_reg <= char_in.char_code;
            last_reg <= char_in.last_char;
        end
        if (advance)
            result_reg <= result;
    end

    vclp_char_class u_class (
        .char_code (char_reg),
        .cls       (cls)
    );

    vclp_parse_core #(
        .NEST_LIMIT (NEST_LIMIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (char_reg),
        .last_char (last_reg),
        .cls       (cls),
        .result    (result)
    );

    assign code_out.valid      = out_valid_reg;
    assign code_out.code_valid = result_reg.code_valid;
    assign code_out.vcp_code   = result_reg.vcp_code;
    assign code_out.list_end   = result_reg.list_end;
    assign code_out.list_found = result_reg.list_found;

    `ASSERT_CLK(a_advance_fills_out, advance |=> out_valid_reg,
        "result register not loaded")
    `ASSERT_CLK(a_hold_input, in_valid_reg && !advance |=>
        in_valid_reg && $stable(char_reg) && $stable(last_reg),
        "pending item lost")
    `ASSERT_CLK(a_ready_when_empty, !out_valid_reg |-> char_in.ready,
        "input blocked with empty result register")
endmodule
